// ===== src/dq_pkg.sv =====
// ---------------------------------------------------------------------------
// dq_pkg: shared constants, codes and types of the double-ended queue
// Holds the depth, field widths, request and status codes, and the
// per-cycle control bundle handed to every storage cell.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dq_pkg;

  localparam int DEPTH   = 16;
  localparam int DATA_W  = 32;
  localparam int REQ_W   = 2;
  localparam int STAT_W  = 2;
  localparam int FILL_W  = 5;
  localparam int CNT_W   = $clog2(DEPTH + 1);

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_FRONT = 2'd0,
    REQ_PUSH_BACK  = 2'd1,
    REQ_POP_FRONT  = 2'd2,
    REQ_POP_BACK   = 2'd3
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // One strobe per operation; at most one is set in a cycle.
  typedef struct packed {
    logic push_front;
    logic push_back;
    logic pop_front;
    logic pop_back;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== src/dq_if.sv =====
// ---------------------------------------------------------------------------
// dq_if: request and response channels of the double-ended queue
// Valid/ready channels; a transfer happens when valid and ready are high.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface dq_req_if import dq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [REQ_W-1:0]         req_type;
  logic signed [DATA_W-1:0] push_value;

  modport source (output valid, output req_type, output push_value, input ready);
  modport sink   (input valid, input req_type, input push_value, output ready);
endinterface

interface dq_rsp_if import dq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic signed [DATA_W-1:0] pop_value;
  logic [FILL_W-1:0]        fill_level;

  modport source (output valid, output status, output pop_value, output fill_level,
                  input ready);
  modport sink   (input valid, input status, input pop_value, input fill_level,
                  output ready);
endinterface

`default_nettype wire

// ===== src/dq_cell.sv =====
// ---------------------------------------------------------------------------
// dq_cell: one storage cell of the queue row
// Holds one entry and its valid bit; shifts toward either neighbor or
// loads the pushed value when it is the first free cell.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dq_cell import dq_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cell_ctrl_t        ctrl,
  input  wire logic [DATA_W-1:0] push_value,
  input  wire logic              prev_valid,
  input  wire logic [DATA_W-1:0] prev_data,
  input  wire logic              next_valid,
  input  wire logic [DATA_W-1:0] next_data,
  output logic                   valid_o,
  output logic [DATA_W-1:0]      data_o,
  output logic                   last_o
);

  logic              valid_r, valid_nxt;
  logic [DATA_W-1:0] data_r, data_nxt;

  assign last_o = valid_r & ~next_valid;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (ctrl.push_front) begin
      valid_nxt = prev_valid;
      data_nxt  = prev_data;
    end else if (ctrl.push_back) begin
      // load only in the first free cell
      if (!valid_r && prev_valid) begin
        valid_nxt = 1'b1;
        data_nxt  = push_value;
      end
    end else if (ctrl.pop_front) begin
      valid_nxt = next_valid;
      data_nxt  = next_data;
    end else if (ctrl.pop_back) begin
      if (last_o) begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;

endmodule

`default_nettype wire

// ===== src/double_ended_queue.sv =====
// ---------------------------------------------------------------------------
// double_ended_queue: double-ended queue of signed 32-bit values
// Row of storage cells with the front at cell 0; every request gives one
// response with status, popped value and fill level.
// ---------------------------------------------------------------------------
// Usage:
//   in_req  : request channel (req_type, push_value). Push front, push back,
//             pop front, pop back.
//   out_rsp : response channel (status, pop_value, fill_level), exactly one
//             response per request, in request order.
//   Latency : a response is valid the cycle after its request transfers.
//   Rate    : one request per cycle. Each request moves every cell of the row
//             by at most one position, and the response register lets the
//             next request in while the current response is being taken.
//   Stall   : while a response waits and out_rsp.ready is low, in_req.ready
//             is low; nothing is lost or repeated.
//   Reset   : rst_n (synchronous, active low) empties the queue at once and
//             drops any pending response; entry data is not cleared.
//   Push on a full queue is dropped with status full; pop on an empty queue
//   reports status empty with pop_value zero. fill_level is the count after
//   the request.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue import dq_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  dq_req_if.sink   in_req,
  dq_rsp_if.source out_rsp
);

  // Cell row wiring
  logic [DEPTH-1:0]  cell_valid;
  logic [DEPTH-1:0]  cell_last;
  logic [DATA_W-1:0] cell_data [DEPTH];
  cell_ctrl_t        ctrl;

  // Control and response registers
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              out_valid_r;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic [DATA_W-1:0] pop_r, pop_nxt;
  logic [FILL_W-1:0] fill_r;

  logic              in_xfer;
  logic              full;
  logic              empty;
  logic [DATA_W-1:0] back_data;

  // Take a request whenever the response register is free or being drained.
  assign in_req.ready = ~out_valid_r | out_rsp.ready;
  assign in_xfer      = in_req.valid & in_req.ready;

  // Front sits in cell 0, so full and empty are single valid bits.
  assign full  = cell_valid[DEPTH-1];
  assign empty = ~cell_valid[0];

  // Select the back entry through the one-hot last marker.
  always_comb begin
    back_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_data = back_data | (cell_data[i] & {DATA_W{cell_last[i]}});
    end
  end

  // Decode the request into cell strobes and the response.
  always_comb begin
    ctrl       = '0;
    count_nxt  = count_r;
    status_nxt = ST_DONE;
    pop_nxt    = '0;
    unique case (req_t'(in_req.req_type)) inside
      REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          ctrl.push_front = in_xfer & (in_req.req_type == REQ_PUSH_FRONT);
          ctrl.push_back  = in_xfer & (in_req.req_type == REQ_PUSH_BACK);
          count_nxt       = count_r + CNT_W'(1);
        end
      end
      REQ_POP_FRONT: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          ctrl.pop_front = in_xfer;
          pop_nxt        = cell_data[0];
          count_nxt      = count_r - CNT_W'(1);
        end
      end
      REQ_POP_BACK: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          ctrl.pop_back = in_xfer;
          pop_nxt       = back_data;
          count_nxt     = count_r - CNT_W'(1);
        end
      end
      default: begin
        status_nxt = ST_DONE;
      end
    endcase
  end

  // Cell row: each cell talks only to its two neighbors.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic              prev_valid;
    logic [DATA_W-1:0] prev_data;
    logic              next_valid;
    logic [DATA_W-1:0] next_data;

    if (g == 0) begin : g_head
      assign prev_valid = 1'b1;
      assign prev_data  = in_req.push_value;
    end else begin : g_mid
      assign prev_valid = cell_valid[g-1];
      assign prev_data  = cell_data[g-1];
    end

    if (g == DEPTH - 1) begin : g_tail
      assign next_valid = 1'b0;
      assign next_data  = '0;
    end else begin : g_body
      assign next_valid = cell_valid[g+1];
      assign next_data  = cell_data[g+1];
    end

    dq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .push_value (in_req.push_value),
      .prev_valid (prev_valid),
      .prev_data  (prev_data),
      .next_valid (next_valid),
      .next_data  (next_data),
      .valid_o    (cell_valid[g]),
      .data_o     (cell_data[g]),
      .last_o     (cell_last[g])
    );
  end

  // Advance the fill count and the response valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        count_r <= count_nxt;
      end
      if (in_xfer) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold the response payload until the next transfer in.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      status_r <= status_nxt;
      pop_r    <= pop_nxt;
      fill_r   <= FILL_W'(count_nxt);
    end
  end

  assign out_rsp.valid      = out_valid_r;
  assign out_rsp.status     = status_r;
  assign out_rsp.pop_value  = pop_r;
  assign out_rsp.fill_level = fill_r;

`ifndef SYNTHESIS
  // Fill count tracks the number of occupied cells.
  a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) == $countones(cell_valid))
    else $error("fill count differs from occupied cells");

  // Occupied cells form one run starting at cell 0.
  a_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot({1'b0, cell_valid} + {{DEPTH{1'b0}}, 1'b1}))
    else $error("occupied cells are not contiguous");

  // An empty-pop response reports a fill level of zero.
  a_empty_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == ST_EMPTY) |-> (fill_r == '0))
    else $error("empty status with nonzero fill level");

  // A full-push response reports a full queue.
  a_full_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == ST_FULL) |-> (fill_r == FILL_W'(DEPTH)))
    else $error("full status with fill level below depth");
`endif

endmodule

`default_nettype wire
